// ===== rtl/srb_pkg.sv =====
package srb_pkg;

    // Ring geometry
    localparam int SLOTS  = 64;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // Fixed field widths
    localparam int SEQ_W = 16;
    localparam int HND_W = 16;
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;
    localparam int OCC_W = 7;

    // Window span as a sequence distance, one bit wider so that it always fits
    localparam logic [SEQ_W:0]   SLOTS_SPAN = (SEQ_W + 1)'(SLOTS);
    // Serial arithmetic: a is before b when (b - a) lies in 1 .. SEQ_HALF - 1
    localparam logic [SEQ_W-1:0] SEQ_HALF   = 16'h8000;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_OUT_WIN = 2'd1;
    localparam logic [ST_W-1:0] ST_DROPPED = 2'd2;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [SEQ_W-1:0]  t_seq;

    // Scan unit request and result
    typedef struct packed {
        t_slot base;
        logic  down;
    } t_scan_req;

    typedef struct packed {
        t_slot idx;
        logic  any;
    } t_scan_res;

    function automatic logic seq_before(input t_seq a, input t_seq b);
        t_seq d;
        d = b - a;
        return (d != '0) && (d < SEQ_HALF);
    endfunction

endpackage

// ===== rtl/srb_ram.sv =====
module srb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; read data holds without a read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/srb_scan.sv =====
module srb_scan import srb_pkg::*; (
    input  logic [SLOTS-1:0] i_vec,
    input  t_scan_req        i_req,
    output t_scan_res        o_res
);

    logic [SLOTS-1:0] rot;
    logic [SLOTS-1:0] low;
    t_slot            pos;

    // Rotate the flag vector so that bit k is the slot k steps from base
    always_comb begin
        rot = '0;
        pos = '0;
        for (int k = 0; k < SLOTS; k++) begin
            pos    = i_req.down ? i_req.base - t_slot'(k) : i_req.base + t_slot'(k);
            rot[k] = i_vec[pos];
        end
    end

    // Isolate the nearest set flag
    assign low = rot & (~rot + {{(SLOTS-1){1'b0}}, 1'b1});

    // One-hot to binary
    always_comb begin
        o_res.idx = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (low[k]) begin
                o_res.idx = o_res.idx | t_slot'(k);
            end
        end
        o_res.any = |rot;
    end

endmodule

// ===== rtl/sequence_reorder_buffer_top.sv =====
// Reorder buffer for a wrapping 16-bit sequence space: a ring of SLOTS handle slots addressed
// by sequence mod SLOTS, with insert, lookup and remove requests and one result per request.
// In the idle state a request is accepted and its slot's handle is read from the single-port-read
// handle RAM; the execute state checks the window, runs the nearest-occupied-slot searches over the
// slot flags and commits the new state together with the result. A result that waits on a stalled
// output lets the next request be taken but holds its commit until the output register frees.
// Slot flags sit in flip-flops and clear at reset, so the block is ready straight after reset
// with no clearing pass; handle storage is never cleared and is only used behind a set flag.
module sequence_reorder_buffer_top import srb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [OP_W-1:0]  i_op,
    input  logic [SEQ_W-1:0] i_seq_index,
    input  logic [HND_W-1:0] i_handle,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_hit,
    output logic [HND_W-1:0] o_old_handle,
    output logic [ST_W-1:0]  o_status,
    output logic [OCC_W-1:0] o_occupancy,
    output logic [SEQ_W-1:0] o_window_start
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    localparam logic [SLOTS-1:0] ONE_HOT0 = {{(SLOTS-1){1'b0}}, 1'b1};

    logic             r_state;
    logic [OP_W-1:0]  r_op;
    t_seq             r_seq;
    logic [HND_W-1:0] r_handle;
    logic [SLOTS-1:0] r_valid;
    t_seq             r_first;
    t_seq             r_end;
    logic [CNT_W-1:0] r_count;

    logic             r_out_valid;
    logic             r_out_hit;
    logic [HND_W-1:0] r_out_old;
    logic [ST_W-1:0]  r_out_status;
    logic [OCC_W-1:0] r_out_occ;
    t_seq             r_out_start;

    logic [SLOTS-1:0] n_valid;
    t_seq             n_first;
    t_seq             n_end;
    logic [CNT_W-1:0] n_count;
    logic             n_hit;
    logic [HND_W-1:0] n_old;
    logic [ST_W-1:0]  n_status;

    logic             in_acc;
    logic             out_free;
    logic             commit;
    logic             ram_we;
    logic [HND_W-1:0] ram_q;

    t_slot            slot;
    logic             hit_raw;
    logic             is_before;
    t_seq             dist_fwd;
    t_seq             dist_back;
    logic             fwd_ok;
    logic             in_win;
    t_seq             nxt;
    logic [SLOTS-1:0] valid_clr;
    logic [SLOTS-1:0] vec_a;
    t_scan_req        req_a;
    t_scan_req        req_b;
    t_scan_res        res_a;
    t_scan_res        res_b;
    t_slot            free_n;
    logic             ins_ok;
    logic [CNT_W-1:0] cnt_after;

    // Handshake
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign commit     = (r_state == S_EXEC) && out_free;

    // Handle storage
    srb_ram #(
        .WIDTH (HND_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we && commit),
        .i_waddr (slot),
        .i_wdata (r_handle),
        .i_re    (in_acc),
        .i_raddr (i_seq_index[SLOT_W-1:0]),
        .o_rdata (ram_q)
    );

    // Window arithmetic on the held request
    assign slot      = r_seq[SLOT_W-1:0];
    assign hit_raw   = r_valid[slot];
    assign is_before = seq_before(r_seq, r_first);
    assign dist_fwd  = r_seq - r_first;
    assign dist_back = r_first - r_seq;
    assign fwd_ok    = {1'b0, dist_fwd} < SLOTS_SPAN;
    assign in_win    = !is_before && fwd_ok;
    assign nxt       = r_seq + SEQ_W'(1);
    assign valid_clr = r_valid & ~(ONE_HOT0 << slot);
    assign cnt_after = hit_raw ? r_count - CNT_W'(1) : r_count;

    // Scan A: free run below the window start on insert, next occupied after it on remove
    assign vec_a      = (r_op == OP_INSERT) ? r_valid : valid_clr;
    assign req_a.base = (r_op == OP_INSERT) ? r_first[SLOT_W-1:0] - t_slot'(1)
                                            : r_first[SLOT_W-1:0] + t_slot'(1);
    assign req_a.down = (r_op == OP_INSERT);

    // Scan B: last occupied slot below the window end on remove
    assign req_b.base = r_end[SLOT_W-1:0] - t_slot'(1);
    assign req_b.down = 1'b1;

    srb_scan u_scan_a (
        .i_vec (vec_a),
        .i_req (req_a),
        .o_res (res_a)
    );

    srb_scan u_scan_b (
        .i_vec (valid_clr),
        .i_req (req_b),
        .o_res (res_b)
    );

    // Free slots below the start, capped one short of the ring
    assign free_n = res_a.any ? res_a.idx : '1;
    assign ins_ok = (r_count == '0) || (is_before ? (dist_back <= SEQ_W'(free_n)) : fwd_ok);

    // Next state and result
    always_comb begin
        n_valid  = r_valid;
        n_first  = r_first;
        n_end    = r_end;
        n_count  = r_count;
        n_hit    = 1'b0;
        n_old    = '0;
        n_status = ST_OK;
        ram_we   = 1'b0;
        unique case (r_op) inside
            OP_INSERT: begin
                if (!ins_ok) begin
                    n_status = ST_DROPPED;
                end else begin
                    ram_we  = 1'b1;
                    n_valid = r_valid | (ONE_HOT0 << slot);
                    if (r_count == '0) begin
                        n_first = r_seq;
                        n_end   = nxt;
                    end else begin
                        if (is_before) begin
                            n_first = r_seq;
                        end
                        if (seq_before(r_end, nxt)) begin
                            n_end = nxt;
                        end
                    end
                    if (hit_raw) begin
                        n_hit = 1'b1;
                        n_old = ram_q;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            OP_LOOKUP, OP_REMOVE: begin
                if (!in_win) begin
                    n_status = ST_OUT_WIN;
                end else begin
                    if (hit_raw) begin
                        n_hit = 1'b1;
                        n_old = ram_q;
                    end
                    if (r_op == OP_REMOVE) begin
                        n_valid = valid_clr;
                        n_count = cnt_after;
                        if (hit_raw && cnt_after == '0) begin
                            n_end = r_first;
                        end
                        // Start moves up to the nearest occupied slot
                        if (r_seq == r_first && cnt_after != '0) begin
                            n_first = r_first + SEQ_W'(1) + SEQ_W'(res_a.idx);
                        end
                        // End moves down to one past the nearest occupied slot
                        if (nxt == r_end && cnt_after != '0) begin
                            n_end = r_end - SEQ_W'(res_b.idx);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_first     <= '0;
            r_end       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (commit) begin
                r_valid     <= n_valid;
                r_first     <= n_first;
                r_end       <= n_end;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= i_op;
            r_seq    <= i_seq_index;
            r_handle <= i_handle;
        end
        if (commit) begin
            r_out_hit    <= n_hit;
            r_out_old    <= n_old;
            r_out_status <= n_status;
            r_out_occ    <= OCC_W'(n_count);
            r_out_start  <= n_first;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_old_handle   = r_out_old;
    assign o_status       = r_out_status;
    assign o_occupancy    = r_out_occ;
    assign o_window_start = r_out_start;

    // Occupancy always matches the slot flags
    a_cnt_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("occupancy count disagrees with slot flags");

    // The window start slot is occupied whenever anything is held
    a_first_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> r_valid[r_first[SLOT_W-1:0]])
        else $error("window start points at an empty slot");

    // Never more entries than slots
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOTS))
        else $error("occupancy above ring size");

    // A refused request returns no handle
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (!o_hit && o_old_handle == '0))
        else $error("refused request reports a handle");

    // A commit frees the block and presents a result
    a_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (r_state == S_IDLE && r_out_valid))
        else $error("commit did not present a result");

endmodule
